### rtl/core/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and codes for the stack machine execute stage.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam logic [7:0] OPC_NOP   = 8'h01;
  localparam logic [7:0] OPC_PUSHI = 8'h10;
  localparam logic [7:0] OPC_PUSHC = 8'h11;
  localparam logic [7:0] OPC_PRN   = 8'h12;
  localparam logic [7:0] OPC_PRC   = 8'h13;
  localparam logic [7:0] OPC_ADD   = 8'h20;
  localparam logic [7:0] OPC_SUB   = 8'h21;
  localparam logic [7:0] OPC_MUL   = 8'h22;
  localparam logic [7:0] OPC_DIV   = 8'h23;
  localparam logic [7:0] OPC_MOD   = 8'h24;
  localparam logic [7:0] OPC_NEG   = 8'h25;
  localparam logic [7:0] OPC_DUP   = 8'h26;
  localparam logic [7:0] OPC_LOAD  = 8'h30;
  localparam logic [7:0] OPC_STORE = 8'h31;
  localparam logic [7:0] OPC_PUSHK = 8'h32;
  localparam logic [7:0] OPC_JMP   = 8'h40;
  localparam logic [7:0] OPC_JEQ   = 8'h41;
  localparam logic [7:0] OPC_JNE   = 8'h42;
  localparam logic [7:0] OPC_JLT   = 8'h43;
  localparam logic [7:0] OPC_JLE   = 8'h44;

  localparam logic [2:0] F_OK    = 3'd0;
  localparam logic [2:0] F_UNDER = 3'd1;
  localparam logic [2:0] F_OVER  = 3'd2;
  localparam logic [2:0] F_DIV0  = 3'd3;
  localparam logic [2:0] F_ADDR  = 3'd4;
  localparam logic [2:0] F_BADOP = 3'd5;

  typedef struct packed {
    logic       known;
    logic [1:0] pops;
    logic [1:0] pushes;
  } shape_t;

  function automatic shape_t op_shape(input logic [7:0] opc);
    shape_t s;
    s = '{known: 1'b1, pops: 2'd0, pushes: 2'd0};
    case (opc) inside
      OPC_NOP, OPC_JMP: ;
      OPC_PUSHI, OPC_PUSHC, OPC_PUSHK: s.pushes = 2'd1;
      OPC_PRN, OPC_PRC: s.pops = 2'd1;
      OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD: begin
        s.pops = 2'd2;
        s.pushes = 2'd1;
      end
      OPC_NEG, OPC_LOAD: begin
        s.pops = 2'd1;
        s.pushes = 2'd1;
      end
      OPC_DUP: begin
        s.pops = 2'd1;
        s.pushes = 2'd2;
      end
      OPC_STORE, OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JLE: s.pops = 2'd2;
      default: s.known = 1'b0;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

### rtl/core/stack_machine_execute.sv
// ----------------------------------------------------------------------------
// stack_machine_execute
// Execute stage of a 32-bit stack machine: operand stack, pc, word memory.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one transaction, either a memory
// preload (op = 0) or one decoded instruction (op = 1). Output channel:
// res_valid/res_stall carry exactly one result transaction per input.
// Sequence: after acceptance a preload, a faulting or a simple instruction
// passes RD0 and RD1 (two stack reads) and EXEC before res_valid rises; a
// load adds MEMRD (memory read port), divide and modulo add DIV, which waits
// on the divider that retires one quotient bit per cycle. One instruction
// is in flight at a time; in_stall stays high from acceptance until its
// result is taken, so a new transaction is accepted only after the previous
// result has been taken.
// Reset clears the stack count, the pc and the control state; stack and
// memory contents are undefined until written. While res_stall is high the
// result holds and no new transaction is accepted.
// ----------------------------------------------------------------------------
module stack_machine_execute #(
  parameter int STACK_DEPTH = 16,
  parameter int MEM_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  opcode,
  input  logic [31:0] operand,
  input  logic [31:0] in_value,
  input  logic [7:0]  load_addr,
  input  logic [31:0] load_data,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  next_pc,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_is_char,
  output logic [2:0]  fault
);
  import sme_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1) + 1;
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_EXEC, S_DIV, S_MEMRD, S_OUT
  } state_t;

  state_t state;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] word_mem  [MEM_DEPTH];

  logic [SCW-1:0] sp;
  logic [7:0]     pc;
  logic           r_op;
  logic [7:0]     r_opc;
  logic [31:0]    r_operand;
  logic [31:0]    r_inval;
  logic [7:0]     r_laddr;
  logic [31:0]    r_ldata;
  logic [31:0]    top;
  logic [31:0]    below;
  logic [31:0]    rd_data;
  logic [SCW-1:0] rd_idx;
  shape_t         shp;

  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dres;

  sme_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (dreq),
    .done   (ddone),
    .result (dres)
  );

  assign shp      = op_shape(r_opc);
  assign in_stall = (state != S_IDLE);
  assign below    = rd_data;
  assign dreq.start    = (state == S_EXEC) && r_op && shp.known
                         && (r_opc == OPC_DIV || r_opc == OPC_MOD)
                         && ({1'b0, sp} >= {{SCW-1{1'b0}}, 2'd2}) && (top != 32'd0);
  assign dreq.is_mod   = (r_opc == OPC_MOD);
  assign dreq.dividend = below;
  assign dreq.divisor  = top;

  logic [2:0]     flt;
  logic [31:0]    res;
  logic           jmp;
  logic [7:0]     npc;
  logic [SCW-1:0] sp_pop;
  logic [SCW+1:0] sp_end;
  logic [31:0]    prod;

  assign sp_pop = sp - {{(SCW-2){1'b0}}, shp.pops};
  assign sp_end = {2'b00, sp_pop} + {{SCW{1'b0}}, shp.pushes};
  assign prod   = below * top;

  always_comb begin
    flt = F_OK;
    if (!r_op) begin
      if ({24'd0, r_laddr} >= 32'(MEM_DEPTH)) flt = F_ADDR;
    end else if (!shp.known) begin
      flt = F_BADOP;
    end else if (sp < {{(SCW-2){1'b0}}, shp.pops}) begin
      flt = F_UNDER;
    end else if (sp_end > (SCW+2)'(STACK_DEPTH)) begin
      flt = F_OVER;
    end else if ((r_opc == OPC_DIV || r_opc == OPC_MOD) && top == 32'd0) begin
      flt = F_DIV0;
    end else if ((r_opc == OPC_LOAD || r_opc == OPC_STORE) && top >= 32'(MEM_DEPTH)) begin
      flt = F_ADDR;
    end
  end

  always_comb begin
    res = 32'd0;
    jmp = 1'b0;
    npc = pc + 8'd1;
    case (r_opc)
      OPC_NOP:   npc = pc;
      OPC_PUSHI: res = r_inval;
      OPC_PUSHC: res = {24'd0, r_inval[7:0]};
      OPC_ADD:   res = below + top;
      OPC_SUB:   res = below - top;
      OPC_MUL:   res = prod;
      OPC_NEG:   res = 32'd0 - top;
      OPC_DUP:   res = top;
      OPC_PUSHK: res = r_operand;
      OPC_JMP:   jmp = 1'b1;
      OPC_JEQ:   jmp = (below == top);
      OPC_JNE:   jmp = (below != top);
      OPC_JLT:   jmp = (below < top);
      OPC_JLE:   jmp = (below <= top);
      default: ;
    endcase
    if (jmp) npc = r_operand[7:0];
  end

  assign rd_idx = (state == S_RD0) ? sp - SCW'(1) : sp - SCW'(2);

  always_ff @(posedge clk) begin
    rd_data <= stack_mem[rd_idx[SAW-1:0]];
  end

  logic            push_en;
  logic [SCW-1:0]  push_idx;
  logic [31:0]     push_val;
  logic            mem_we;
  logic [MAW-1:0]  mem_wa;
  logic [31:0]     mem_wd;
  logic [31:0]     mem_rd;

  always_ff @(posedge clk) begin
    if (push_en) stack_mem[push_idx[SAW-1:0]] <= push_val;
  end

  always_ff @(posedge clk) begin
    if (mem_we) word_mem[mem_wa] <= mem_wd;
    mem_rd <= word_mem[top[MAW-1:0]];
  end

  always_comb begin
    push_en  = 1'b0;
    push_idx = sp_pop;
    push_val = res;
    mem_we   = 1'b0;
    mem_wa   = MAW'(r_laddr);
    mem_wd   = r_ldata;
    if (state == S_EXEC) begin
      if (!r_op) begin
        mem_we = (flt == F_OK);
      end else if (flt == F_OK) begin
        if (r_opc == OPC_STORE) begin
          mem_we = 1'b1;
          mem_wa = top[MAW-1:0];
          mem_wd = below;
        end
        if (r_opc == OPC_DUP) push_idx = sp;
        push_en = (shp.pushes != 2'd0) && r_opc != OPC_DIV && r_opc != OPC_MOD
                  && r_opc != OPC_LOAD;
      end
    end else if (state == S_DIV && ddone) begin
      push_en  = 1'b1;
      push_idx = sp;
      push_val = dres;
    end else if (state == S_MEMRD) begin
      push_en  = 1'b1;
      push_idx = sp;
      push_val = mem_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sp         <= '0;
      pc         <= 8'd0;
      res_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_op      <= op;
            r_opc     <= opcode;
            r_operand <= operand;
            r_inval   <= in_value;
            r_laddr   <= load_addr;
            r_ldata   <= load_data;
            state     <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          top   <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          fault <= flt;
          if (r_op && flt == F_OK) begin
            pc          <= npc;
            next_pc     <= npc;
            out_valid   <= (r_opc == OPC_PRN || r_opc == OPC_PRC);
            out_value   <= (r_opc == OPC_PRN || r_opc == OPC_PRC) ? top : 32'd0;
            out_is_char <= (r_opc == OPC_PRC);
          end else begin
            next_pc     <= pc;
            out_valid   <= 1'b0;
            out_value   <= 32'd0;
            out_is_char <= 1'b0;
          end
          if (r_op && flt == F_OK && (r_opc == OPC_DIV || r_opc == OPC_MOD)) begin
            sp    <= sp_pop;
            state <= S_DIV;
          end else if (r_op && flt == F_OK && r_opc == OPC_LOAD) begin
            sp    <= sp_pop;
            state <= S_MEMRD;
          end else begin
            if (r_op && flt == F_OK) sp <= sp_end[SCW-1:0];
            state     <= S_OUT;
            res_valid <= 1'b1;
          end
        end
        S_DIV: begin
          if (ddone) begin
            sp        <= sp + SCW'(1);
            state     <= S_OUT;
            res_valid <= 1'b1;
          end
        end
        S_MEMRD: begin
          sp        <= sp + SCW'(1);
          state     <= S_OUT;
          res_valid <= 1'b1;
        end
        S_OUT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/sme_divider.sv
// ----------------------------------------------------------------------------
// sme_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
  input  logic              clk,
  input  logic              rst,
  input  sme_pkg::div_req_t req,
  output logic              done,
  output logic [31:0]       result
);
  import sme_pkg::*;

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        is_mod;
  logic [32:0] trial;

  assign trial  = {rem, quo[31]} - {1'b0, dvs};
  assign result = is_mod ? rem : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        quo    <= req.dividend;
        rem    <= '0;
        dvs    <= req.divisor;
        is_mod <= req.is_mod;
        cnt    <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute stage testbench
// Drives preloads and instruction streams with random idling on both sides,
// predicts each result from a software copy of stack, pc and memory, and
// compares every result field in order of arrival.
// ----------------------------------------------------------------------------
import sme_pkg::*;

typedef struct packed {
  logic        op;
  logic [7:0]  opcode;
  logic [31:0] operand;
  logic [31:0] in_value;
  logic [7:0]  load_addr;
  logic [31:0] load_data;
} instr_t;

typedef struct packed {
  logic [7:0]  next_pc;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_is_char;
  logic [2:0]  fault;
} exec_res_t;

class exec_scoreboard;
  logic [31:0] stk [16];
  int          depth;
  logic [7:0]  pc;
  logic [31:0] mem [256];
  bit          written [256];
  exec_res_t   pending [$];
  int          errors;

  function new();
    depth = 0;
    pc = '0;
    errors = 0;
    foreach (written[i]) written[i] = 0;
  endfunction

  function void note_instr(instr_t t);
    exec_res_t r;
    int pops, pushes;
    logic [31:0] top, below, val;
    logic [7:0] npc;
    bit known;
    r = '0;
    top = '0;
    below = '0;
    val = '0;
    known = 1;
    pops = 0;
    pushes = 0;
    if (!t.op) begin
      mem[t.load_addr] = t.load_data;
      written[t.load_addr] = 1;
    end else begin
      case (t.opcode)
        OPC_NOP, OPC_JMP: ;
        OPC_PUSHI, OPC_PUSHC, OPC_PUSHK: pushes = 1;
        OPC_PRN, OPC_PRC: pops = 1;
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD: begin pops = 2; pushes = 1; end
        OPC_NEG, OPC_LOAD: begin pops = 1; pushes = 1; end
        OPC_DUP: begin pops = 1; pushes = 2; end
        OPC_STORE, OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JLE: pops = 2;
        default: known = 0;
      endcase
      if (pops >= 1 && depth >= pops) top = stk[depth-1];
      if (pops >= 2 && depth >= pops) below = stk[depth-2];
      if (!known) r.fault = F_BADOP;
      else if (depth < pops) r.fault = F_UNDER;
      else if (depth - pops + pushes > 16) r.fault = F_OVER;
      else if ((t.opcode == OPC_DIV || t.opcode == OPC_MOD) && top == 0) r.fault = F_DIV0;
      else if ((t.opcode == OPC_LOAD || t.opcode == OPC_STORE) && top >= 256)
        r.fault = F_ADDR;
      if (r.fault == F_OK) begin
        npc = pc + 8'd1;
        case (t.opcode)
          OPC_NOP: npc = pc;
          OPC_PUSHI: val = t.in_value;
          OPC_PUSHC: val = {24'd0, t.in_value[7:0]};
          OPC_PRN: begin r.out_valid = 1'b1; r.out_value = top; end
          OPC_PRC: begin r.out_valid = 1'b1; r.out_value = top; r.out_is_char = 1'b1; end
          OPC_ADD: val = below + top;
          OPC_SUB: val = below - top;
          OPC_MUL: val = below * top;
          OPC_DIV: val = below / top;
          OPC_MOD: val = below % top;
          OPC_NEG: val = -top;
          OPC_DUP: val = top;
          OPC_LOAD: val = mem[top[7:0]];
          OPC_STORE: begin mem[top[7:0]] = below; written[top[7:0]] = 1; end
          OPC_PUSHK: val = t.operand;
          OPC_JMP: npc = t.operand[7:0];
          OPC_JEQ: if (below == top) npc = t.operand[7:0];
          OPC_JNE: if (below != top) npc = t.operand[7:0];
          OPC_JLT: if (below < top) npc = t.operand[7:0];
          OPC_JLE: if (below <= top) npc = t.operand[7:0];
          default: ;
        endcase
        depth -= pops;
        repeat (pushes) begin stk[depth] = val; depth++; end
        pc = npc;
      end
    end
    r.next_pc = pc;
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(exec_res_t got);
    exec_res_t exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch expected: pc=%h ov=%b val=%h ch=%b f=%0d",
                 exp.next_pc, exp.out_valid, exp.out_value, exp.out_is_char, exp.fault);
        $display("         actual:   pc=%h ov=%b val=%h ch=%b f=%0d",
                 got.next_pc, got.out_valid, got.out_value, got.out_is_char, got.fault);
      end
    end
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        op = 0;
  logic [7:0]  opcode = '0;
  logic [31:0] operand = '0;
  logic [31:0] in_value = '0;
  logic [7:0]  load_addr = '0;
  logic [31:0] load_data = '0;
  logic        res_valid;
  logic        res_stall = 0;
  logic [7:0]  next_pc;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_is_char;
  logic [2:0]  fault;

  localparam logic [7:0] OPC_UNDEF_LO = 8'h00;
  localparam logic [7:0] OPC_UNDEF_HI = 8'hFF;

  exec_scoreboard sb = new();
  int  send_idle = 31;
  int  recv_idle = 81;
  int  hold_left = 0;
  bit  hold_start = 0;
  bit  hold_used = 0;
  int  cycles = 0;

  always #5 clk = ~clk;

  stack_machine_execute uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result('{next_pc, out_valid, out_value, out_is_char, fault});
    res_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (hold_start && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1;
    end else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  // model depth mirrors what the block will hold once all sent items retire
  task automatic send(instr_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {op, opcode, operand, in_value, load_addr, load_data} <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instr(t);
  endtask

  function automatic instr_t mk(logic [7:0] opc, logic [31:0] k = 0);
    instr_t t;
    t = '0;
    t.op = 1;
    t.opcode = opc;
    t.operand = k;
    t.in_value = $urandom();
    return t;
  endfunction

  function automatic instr_t preload(logic [7:0] a, logic [31:0] d);
    instr_t t;
    t = '0;
    t.load_addr = a;
    t.load_data = d;
    t.operand = $urandom();
    t.in_value = $urandom();
    t.opcode = 8'($urandom());
    return t;
  endfunction

  logic [7:0] all_ops [20] = '{OPC_NOP, OPC_PUSHI, OPC_PUSHC, OPC_PRN, OPC_PRC, OPC_ADD,
    OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD, OPC_NEG, OPC_DUP, OPC_LOAD, OPC_STORE, OPC_PUSHK,
    OPC_JMP, OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JLE};

  // pick a value: all ones, zero, one in 0 to 300 or an arbitrary one
  function automatic logic [31:0] pick_val();
    case ($urandom_range(5))
      0: return 32'hFFFFFFFF;
      1: return 0;
      2: return $urandom_range(300);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_item();
    instr_t t;
    logic [7:0] opc;
    logic [31:0] a;
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      send(preload(8'($urandom()), $urandom()));
    end else if (r < 35) begin
      send(mk(OPC_PUSHK, pick_val()));
    end else if (r < 40) begin
      t = mk(OPC_PUSHI);
      t.in_value = pick_val();
      send(t);
    end else if (r < 45) begin
      opc = 8'($urandom());
      t = mk(opc, $urandom());
      t.load_addr = 8'($urandom());
      t.load_data = $urandom();
      if (opc != OPC_LOAD) send(t);
    end else if (r < 55) begin
      // load only from a written address
      a = $urandom_range(255);
      if (!sb.written[a]) send(preload(a[7:0], $urandom()));
      send(mk(OPC_PUSHK, a));
      if (sb.depth == 0 || sb.stk[sb.depth-1] >= 256 || sb.written[sb.stk[sb.depth-1][7:0]])
        send(mk(OPC_LOAD));
    end else if (r < 62) begin
      send(mk(OPC_PUSHK, $urandom_range(255)));
      send(mk(OPC_STORE));
    end else begin
      opc = all_ops[$urandom_range(19)];
      if (opc == OPC_LOAD) opc = OPC_NEG;
      send(mk(opc, $urandom()));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(mk(OPC_PRN));
    send(mk(OPC_ADD));
    send(mk(OPC_UNDEF_LO));
    send(mk(OPC_UNDEF_HI));
    send(preload(8'hFF, 32'hFFFFFFFF));
    send(preload(8'h00, 32'h0));
    send(mk(OPC_PUSHK, 32'hFFFFFFFF));
    send(mk(OPC_PUSHK, 0));
    send(mk(OPC_DIV));
    send(mk(OPC_MOD));
    send(mk(OPC_PUSHK, 32'h100));
    send(mk(OPC_LOAD));
    send(mk(OPC_PUSHK, 32'hFF));
    send(mk(OPC_LOAD));
    send(mk(OPC_JLE, 32'hFFFFFFFF));
    send(mk(OPC_NOP));
    send(mk(OPC_JMP, 32'hFF));
    send(mk(OPC_NOP));
    repeat (17) send(mk(OPC_PUSHK, $urandom()));
    send(mk(OPC_PRC));
    send(mk(OPC_PRN));
    for (int i = 0; i < 1160; i++) begin
      if (i == 390) begin
        send_idle = 81;
        recv_idle = 31;
      end
      if (i == 775) begin
        send_idle = 0;
        recv_idle = 0;
        hold_start = 1;
      end
      random_item();
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
rtl/core/sme_pkg.sv
rtl/core/sme_divider.sv
rtl/core/stack_machine_execute.sv
verif/testbench.sv
